// ===== rtl/core/dws_pkg.sv =====
// Shared types and codes for the DAC waveform sequencer.
// Holds request, mode, frame and item-layout constants, the run-mode enum and the result struct; no dependencies.
`timescale 1ns / 1ps

package dws_pkg;

    // Request kinds carried in the slave-side tuser
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;

    // Start modes
    localparam logic [2:0] MODE_STOP    = 3'd0;
    localparam logic [2:0] MODE_FIXED   = 3'd1;
    localparam logic [2:0] MODE_TRI     = 3'd2;
    localparam logic [2:0] MODE_ARB     = 3'd3;
    localparam logic [2:0] MODE_REF_ON  = 3'd4;
    localparam logic [2:0] MODE_REF_OFF = 3'd5;

    // DAC frame fields
    localparam logic [7:0]  CMD_WRITE    = 8'h03;
    localparam logic [7:0]  CMD_REF      = 8'h08;
    localparam logic [7:0]  TRAILER      = 8'h55;
    localparam logic [11:0] PACE_DEFAULT = 12'd1000;

    // Input item layout inside s_axis_tdata
    localparam int IN_DATA_W = 64;
    localparam int MODE_LSB  = 0;
    localparam int CHAN_LSB  = 3;
    localparam int VALUE_LSB = 7;
    localparam int COUNT_LSB = 19;
    localparam int INDEX_LSB = 27;
    localparam int WORD_LSB  = 35;

    typedef enum logic [2:0] {
        RUN_IDLE = 3'b001,
        RUN_TRI  = 3'b010,
        RUN_ARB  = 3'b100
    } run_mode_t;

    typedef struct packed {
        logic [31:0] word;
        logic        done;
    } dac_result_t;

endpackage

// ===== rtl/core/dws_sdp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps

module dws_sdp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dac_waveform_sequencer_unit.sv =====
// DAC waveform sequencer: start, tick and load items in, 32-bit DAC frames out.
// Each result is formed from its accepted item and registered in the output buffer.
// Throughput: one item per cycle; a two-entry output buffer (register plus skid) keeps
// s_axis_tready high unless both entries are full.
// Reset (rst_n, async, active low): idle, pace reload 1000, counters and buffer cleared.
// Sample store: no reset; the user must load entries before reading; never checked.
`timescale 1ns / 1ps

module dac_waveform_sequencer_unit #(
    parameter int SAMPLE_DEPTH = 256,
    parameter int DAC_BITS     = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] mode, [6:3] channel, [18:7] value, [26:19] count,
    // [34:27] sample_index, [58:35] sample_word, [63:59] zero
    input  logic [dws_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] dac_word
    output logic [31:0]                   m_axis_tdata,
    // done_res
    output logic                          m_axis_tlast
);

    import dws_pkg::*;

    localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam logic [DAC_BITS-1:0] RAMP_TOP = {DAC_BITS{1'b1}};

    // Unpack the input item
    logic [1:0]  in_req;
    logic [2:0]  in_mode;
    logic [3:0]  in_chan;
    logic [11:0] in_value;
    logic [7:0]  in_count;
    logic [7:0]  in_index;
    logic [23:0] in_word;

    assign in_req   = s_axis_tuser;
    assign in_mode  = s_axis_tdata[MODE_LSB +: 3];
    assign in_chan  = s_axis_tdata[CHAN_LSB +: 4];
    assign in_value = s_axis_tdata[VALUE_LSB +: 12];
    assign in_count = s_axis_tdata[COUNT_LSB +: 8];
    assign in_index = s_axis_tdata[INDEX_LSB +: 8];
    assign in_word  = s_axis_tdata[WORD_LSB +: 24];

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    // Sequencer state
    run_mode_t           run_mode_reg, run_mode_next;
    logic [3:0]          chan_reg, chan_next;
    logic [11:0]         pace_reload_reg, pace_reload_next;
    logic [11:0]         pace_count_reg, pace_count_next;
    logic [DAC_BITS-1:0] ramp_level_reg, ramp_level_next;
    logic                ramp_falling_reg, ramp_falling_next;
    logic [7:0]          cycles_left_reg, cycles_left_next;
    logic                endless_reg, endless_next;
    logic [7:0]          play_length_reg, play_length_next;
    logic [7:0]          play_index_reg, play_index_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic                low_half_reg, low_half_next;

    // Sample store and write-to-read bypass
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [23:0]   ram_rdata;
    logic [31:0]   index_ext;
    logic          byp_valid_reg;
    logic [23:0]   byp_data_reg;
    logic [23:0]   play_word;

    assign index_ext = 32'(in_index);
    assign ram_we    = accept && (in_req == REQ_LOAD) && (index_ext < 32'(SAMPLE_DEPTH));
    assign ram_waddr = index_ext[AW-1:0];

    dws_sdp_ram #(
        .WIDTH (24),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_word),
        .raddr (rd_ptr_next),
        .rdata (ram_rdata)
    );

    // The RAM is read every cycle at the index the next tick will play; a load to that
    // very entry in the same cycle would be missed by the read, so carry it across here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            byp_valid_reg <= ram_we && (ram_waddr == rd_ptr_next);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= in_word;
    end

    assign play_word = byp_valid_reg ? byp_data_reg : ram_rdata;

    // Ramp level placed MSB-justified in the 12-bit sample field
    logic [DAC_BITS+11:0] ramp_scaled;
    logic [11:0]          ramp_sample;

    assign ramp_scaled = {ramp_level_reg, 12'd0} >> DAC_BITS;
    assign ramp_sample = ramp_scaled[11:0];

    // Per-item logic
    logic        res_valid;
    dac_result_t res;
    logic [11:0] arb_sample;
    logic [8:0]  index_inc;

    assign arb_sample = low_half_reg ? play_word[11:0] : play_word[23:12];
    assign index_inc  = {1'b0, play_index_reg} + 9'd1;

    always_comb
    begin
        run_mode_next     = run_mode_reg;
        chan_next         = chan_reg;
        pace_reload_next  = pace_reload_reg;
        pace_count_next   = pace_count_reg;
        ramp_level_next   = ramp_level_reg;
        ramp_falling_next = ramp_falling_reg;
        cycles_left_next  = cycles_left_reg;
        endless_next      = endless_reg;
        play_length_next  = play_length_reg;
        play_index_next   = play_index_reg;
        rd_ptr_next       = rd_ptr_reg;
        low_half_next     = low_half_reg;
        res_valid         = 1'b0;
        res.word          = 32'd0;
        res.done          = 1'b0;

        if (accept)
        begin
            case (in_req)
                REQ_START:
                begin
                    // Any start aborts the running job
                    run_mode_next = RUN_IDLE;
                    chan_next     = in_chan;
                    case (in_mode)
                        MODE_FIXED:
                        begin
                            res_valid = 1'b1;
                            res.word  = {CMD_WRITE, in_chan, in_value, TRAILER};
                            res.done  = 1'b1;
                        end
                        MODE_TRI:
                        begin
                            pace_reload_next  = (in_value != 12'd0) ? in_value : PACE_DEFAULT;
                            pace_count_next   = 12'd0;
                            ramp_level_next   = '0;
                            ramp_falling_next = 1'b0;
                            cycles_left_next  = in_count;
                            endless_next      = (in_count == 8'd0);
                            run_mode_next     = RUN_TRI;
                        end
                        MODE_ARB:
                        begin
                            play_length_next = in_count;
                            play_index_next  = 8'd0;
                            rd_ptr_next      = '0;
                            low_half_next    = 1'b0;
                            if (in_count != 8'd0)
                            begin
                                run_mode_next = RUN_ARB;
                            end
                        end
                        MODE_REF_ON, MODE_REF_OFF:
                        begin
                            res_valid = 1'b1;
                            res.word  = {CMD_REF, 23'd0, (in_mode == MODE_REF_ON)};
                            res.done  = 1'b1;
                        end
                        default:
                        begin
                            // stop or unknown mode: just go idle
                        end
                    endcase
                end

                REQ_TICK:
                begin
                    if (run_mode_reg == RUN_TRI)
                    begin
                        if (pace_count_reg != 12'd0)
                        begin
                            pace_count_next = pace_count_reg - 12'd1;
                        end
                        else
                        begin
                            pace_count_next = pace_reload_reg - 12'd1;
                            res_valid       = 1'b1;
                            res.word        = {CMD_WRITE, chan_reg, ramp_sample, TRAILER};
                            if (!ramp_falling_reg)
                            begin
                                // Hold the top for one extra frame before turning down
                                if (ramp_level_reg == RAMP_TOP)
                                begin
                                    ramp_falling_next = 1'b1;
                                end
                                else
                                begin
                                    ramp_level_next = ramp_level_reg + 1'b1;
                                end
                            end
                            else if (ramp_level_reg != '0)
                            begin
                                ramp_level_next = ramp_level_reg - 1'b1;
                            end
                            else if (endless_reg || (cycles_left_reg > 8'd1))
                            begin
                                if (!endless_reg)
                                begin
                                    cycles_left_next = cycles_left_reg - 8'd1;
                                end
                                ramp_falling_next = 1'b0;
                            end
                            else
                            begin
                                cycles_left_next = 8'd0;
                                res.done         = 1'b1;
                                run_mode_next    = RUN_IDLE;
                            end
                        end
                    end
                    else if (run_mode_reg == RUN_ARB)
                    begin
                        res_valid = 1'b1;
                        res.word  = {CMD_WRITE, chan_reg, arb_sample, TRAILER};
                        if (low_half_reg)
                        begin
                            // Advance to the next word, looping over the play length
                            if (index_inc >= {1'b0, play_length_reg})
                            begin
                                play_index_next = 8'd0;
                                rd_ptr_next     = '0;
                            end
                            else
                            begin
                                play_index_next = index_inc[7:0];
                                rd_ptr_next     = (32'(rd_ptr_reg) + 32'd1 >= 32'(SAMPLE_DEPTH))
                                                ? '0 : rd_ptr_reg + 1'b1;
                            end
                            low_half_next = 1'b0;
                        end
                        else
                        begin
                            low_half_next = 1'b1;
                        end
                    end
                end

                default:
                begin
                    // loads go straight to the store; unknown requests are dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mode_reg     <= RUN_IDLE;
            chan_reg         <= 4'd0;
            pace_reload_reg  <= PACE_DEFAULT;
            pace_count_reg   <= 12'd0;
            ramp_level_reg   <= '0;
            ramp_falling_reg <= 1'b0;
            cycles_left_reg  <= 8'd0;
            endless_reg      <= 1'b0;
            play_length_reg  <= 8'd0;
            play_index_reg   <= 8'd0;
            rd_ptr_reg       <= '0;
            low_half_reg     <= 1'b0;
        end
        else
        begin
            run_mode_reg     <= run_mode_next;
            chan_reg         <= chan_next;
            pace_reload_reg  <= pace_reload_next;
            pace_count_reg   <= pace_count_next;
            ramp_level_reg   <= ramp_level_next;
            ramp_falling_reg <= ramp_falling_next;
            cycles_left_reg  <= cycles_left_next;
            endless_reg      <= endless_next;
            play_length_reg  <= play_length_next;
            play_index_reg   <= play_index_next;
            rd_ptr_reg       <= rd_ptr_next;
            low_half_reg     <= low_half_next;
        end
    end

    // Output register plus skid entry
    logic        out_valid_reg, out_valid_next;
    dac_result_t out_reg, out_next;
    logic        skid_valid_reg, skid_valid_next;
    dac_result_t skid_reg, skid_next;
    logic        pop;

    assign pop = out_valid_reg && m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (pop)
        begin
            // Refill the output from the skid entry, else from the new result
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Ready drops only while the skid entry is occupied
    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.word;
    assign m_axis_tlast  = out_reg.done;

endmodule

// ===== bench/dws_checker.sv =====
// Scoreboard for the DAC waveform sequencer: watches both stream channels,
// predicts every DAC frame from the accepted items and compares word and done flag.
// Depends on dws_pkg for request/mode codes, frame constants and the item layout.
`timescale 1ns / 1ps

module dws_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [dws_pkg::IN_DATA_W-1:0] s_data,
    input  logic [1:0]                    s_user,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [31:0]                   m_data,
    input  logic                          m_last,
    output int                            failures,
    output int                            pending
);

    import dws_pkg::*;

    localparam int REPORT_CAP = 100;

    // Shadow of the sequencer state
    run_mode_t   run_state;
    logic [3:0]  chan_q;
    logic [11:0] pace_reload;
    logic [11:0] pace_left;
    logic [11:0] ramp_level;
    logic        ramp_falling;
    logic [7:0]  cycles_left;
    logic        endless;
    logic [23:0] samples [0:255];
    logic [7:0]  play_length;
    logic [7:0]  play_index;
    logic        low_half;

    // Frames still owed by the block, oldest first
    logic [31:0] words_due [$];
    logic        last_due [$];

    function automatic logic [31:0] dac_frame(input logic [3:0] chan, input logic [11:0] smp);
        return {CMD_WRITE, chan, smp, TRAILER};
    endfunction

    task automatic queue_frame(input logic [31:0] word, input logic last);
        words_due.push_back(word);
        last_due.push_back(last);
    endtask

    task automatic start_job(input logic [IN_DATA_W-1:0] d);
        logic [2:0]  mode;
        logic [3:0]  chan;
        logic [11:0] value;
        logic [7:0]  count;
        mode  = d[MODE_LSB +: 3];
        chan  = d[CHAN_LSB +: 4];
        value = d[VALUE_LSB +: 12];
        count = d[COUNT_LSB +: 8];
        // any start drops the running job
        run_state = RUN_IDLE;
        chan_q    = chan;
        case (mode)
            MODE_FIXED: queue_frame(dac_frame(chan, value), 1'b1);
            MODE_TRI:
            begin
                pace_reload  = (value != 12'd0) ? value : PACE_DEFAULT;
                pace_left    = 12'd0;
                ramp_level   = 12'd0;
                ramp_falling = 1'b0;
                cycles_left  = count;
                endless      = (count == 8'd0);
                run_state    = RUN_TRI;
            end
            MODE_ARB:
            begin
                play_length = count;
                play_index  = 8'd0;
                low_half    = 1'b0;
                if (count != 8'd0)
                    run_state = RUN_ARB;
            end
            MODE_REF_ON:  queue_frame({CMD_REF, 24'd1}, 1'b1);
            MODE_REF_OFF: queue_frame({CMD_REF, 24'd0}, 1'b1);
            default: ;
        endcase
    endtask

    task automatic tick_ramp();
        logic [31:0] word;
        logic        fin;
        fin = 1'b0;
        if (pace_left != 12'd0)
            pace_left = pace_left - 12'd1;
        else
        begin
            pace_left = pace_reload - 12'd1;
            word      = dac_frame(chan_q, ramp_level);
            if (!ramp_falling)
            begin
                if (ramp_level == 12'hFFF)
                    ramp_falling = 1'b1;
                else
                    ramp_level = ramp_level + 12'd1;
            end
            else if (ramp_level != 12'd0)
                ramp_level = ramp_level - 12'd1;
            else if (endless || cycles_left > 8'd1)
            begin
                if (!endless)
                    cycles_left = cycles_left - 8'd1;
                ramp_falling = 1'b0;
            end
            else
            begin
                cycles_left = 8'd0;
                fin         = 1'b1;
                run_state   = RUN_IDLE;
            end
            queue_frame(word, fin);
        end
    endtask

    task automatic tick_playback();
        logic [23:0] w;
        w = samples[play_index];
        queue_frame(dac_frame(chan_q, low_half ? w[11:0] : w[23:12]), 1'b0);
        if (low_half)
        begin
            play_index = ({1'b0, play_index} + 9'd1 >= {1'b0, play_length}) ?
                         8'd0 : play_index + 8'd1;
            low_half   = 1'b0;
        end
        else
            low_half = 1'b1;
    endtask

    task automatic apply_item(input logic [1:0] req, input logic [IN_DATA_W-1:0] d);
        case (req)
            REQ_START: start_job(d);
            REQ_TICK:
            begin
                if (run_state == RUN_TRI)
                    tick_ramp();
                else if (run_state == RUN_ARB)
                    tick_playback();
            end
            REQ_LOAD: samples[d[INDEX_LSB +: 8]] = d[WORD_LSB +: 24];
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want_word;
        logic        want_last;
        if (!rst_n)
        begin
            run_state    = RUN_IDLE;
            chan_q       = 4'd0;
            pace_reload  = PACE_DEFAULT;
            pace_left    = 12'd0;
            ramp_level   = 12'd0;
            ramp_falling = 1'b0;
            cycles_left  = 8'd0;
            endless      = 1'b0;
            play_length  = 8'd0;
            play_index   = 8'd0;
            low_half     = 1'b0;
            words_due.delete();
            last_due.delete();
            failures     = 0;
            pending      = 0;
        end
        else
        begin
            if (m_valid && m_ready)
            begin
                if (words_due.size() == 0)
                begin
                    failures = failures + 1;
                    if (failures <= REPORT_CAP)
                        $display("%0t: unexpected frame: expected none, actual %h last %b",
                                 $time, m_data, m_last);
                end
                else
                begin
                    want_word = words_due.pop_front();
                    want_last = last_due.pop_front();
                    if (m_data !== want_word)
                    begin
                        failures = failures + 1;
                        if (failures <= REPORT_CAP)
                            $display("%0t: dac_word mismatch: expected %h, actual %h",
                                     $time, want_word, m_data);
                    end
                    if (m_last !== want_last)
                    begin
                        failures = failures + 1;
                        if (failures <= REPORT_CAP)
                            $display("%0t: done mismatch: expected %b, actual %b",
                                     $time, want_last, m_last);
                    end
                end
            end
            if (s_valid && s_ready)
                apply_item(s_user, s_data);
            pending = words_due.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the DAC waveform sequencer bench: clock, reset, stimulus and verdict.
// Instantiates dac_waveform_sequencer_unit and dws_checker; uses dws_pkg codes.
`timescale 1ns / 1ps

module tb_top;

    import dws_pkg::*;

    // Codes the package leaves unnamed: the two unused modes and request kind
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Cycles with no item moving on either side before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to keep watching once nothing is owed, for stray frames
    localparam int END_DRAIN      = 8;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    // Slave side: start, tick and load items into the block
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    // [2:0] mode, [6:3] channel, [18:7] value, [26:19] count,
    // [34:27] sample_index, [58:35] sample_word, [63:59] zero
    logic [IN_DATA_W-1:0] s_data = '0;
    // [1:0] req_type
    logic [1:0]           s_user = REQ_TICK;

    // Master side: DAC frames out of the block
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    // [31:0] dac_word
    logic [31:0]          m_data;
    // done_res
    logic                 m_last;

    // Idle chances, in percent, for the sender and the receiver
    int                   src_idle_pct = 15;
    int                   sink_idle_pct = 62;

    int                   items_sent = 0;
    int                   quiet_cycles = 0;
    int                   failures;
    int                   pending;

    always #4 clk = ~clk;

    dac_waveform_sequencer_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last)
    );

    dws_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .s_user   (s_user),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .m_last   (m_last),
        .failures (failures),
        .pending  (pending)
    );

    // Receiver back-pressure: drop ready at random, at the current idle chance
    always @(posedge clk)
        m_ready <= ($urandom_range(99) >= sink_idle_pct);

    // Watchdog: give up when nothing has moved on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, no item moved for %0d cycles",
                     $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [IN_DATA_W-1:0] pack_item(
        input logic [2:0]  mode,
        input logic [3:0]  chan,
        input logic [11:0] value,
        input logic [7:0]  count,
        input logic [7:0]  index,
        input logic [23:0] word
    );
        logic [IN_DATA_W-1:0] d;
        d                   = '0;
        d[MODE_LSB +: 3]    = mode;
        d[CHAN_LSB +: 4]    = chan;
        d[VALUE_LSB +: 12]  = value;
        d[COUNT_LSB +: 8]   = count;
        d[INDEX_LSB +: 8]   = index;
        d[WORD_LSB +: 24]   = word;
        return d;
    endfunction

    // Every field random; unused fields carry junk so their bits toggle; [63:59] stay zero.
    function automatic logic [IN_DATA_W-1:0] junk_item();
        return pack_item(3'($urandom_range(7)), 4'($urandom_range(15)),
                         12'($urandom_range(4095)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 24'($urandom_range(24'hFFFFFF)));
    endfunction

    // Offer one item and hold it until the block takes it. Idle gaps come first, so
    // tvalid gets a single assignment per clock edge.
    task automatic send_item(input logic [1:0] req, input logic [IN_DATA_W-1:0] d);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= req;
        s_data  <= d;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        items_sent = items_sent + 1;
    endtask

    task automatic start_cmd(
        input logic [2:0]  mode,
        input logic [3:0]  chan,
        input logic [11:0] value,
        input logic [7:0]  count
    );
        send_item(REQ_START, pack_item(mode, chan, value, count, 8'($urandom_range(255)),
                                       24'($urandom_range(24'hFFFFFF))));
    endtask

    task automatic load_word(input logic [7:0] index, input logic [23:0] word);
        send_item(REQ_LOAD, pack_item(3'($urandom_range(7)), 4'($urandom_range(15)),
                                      12'($urandom_range(4095)), 8'($urandom_range(255)),
                                      index, word));
    endtask

    // Send n ticks; now and then slip in a sample load instead
    task automatic tick_run(input int n, input int load_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < load_pct)
                load_word(8'($urandom_range(255)), 24'($urandom_range(24'hFFFFFF)));
            else
                send_item(REQ_TICK, junk_item());
        end
    endtask

    // Short directed opening: field extremes, every mode and the corner cases
    task automatic directed_items();
        send_item(REQ_TICK, junk_item());                  // tick while idle: ignored
        start_cmd(MODE_FIXED, 4'd0, 12'd0, 8'd0);
        start_cmd(MODE_FIXED, 4'd15, 12'hFFF, 8'hFF);
        start_cmd(MODE_REF_ON, 4'd15, 12'hFFF, 8'hFF);
        start_cmd(MODE_REF_OFF, 4'd0, 12'd0, 8'd0);
        start_cmd(MODE_RSVD6, 4'd5, 12'd7, 8'd3);
        start_cmd(MODE_RSVD7, 4'd10, 12'd9, 8'd1);
        send_item(REQ_UNUSED, junk_item());                // unknown request: ignored
        load_word(8'd0, 24'hFFFFFF);
        load_word(8'd1, 24'h000000);
        load_word(8'd255, 24'h5A5A5A);
        // two-word playback; five ticks wrap back to the first word
        start_cmd(MODE_ARB, 4'd9, 12'd0, 8'd2);
        tick_run(5, 0);
        // overwrite an entry mid-playback: the new word shows on its next read
        load_word(8'd1, 24'h123ABC);
        tick_run(3, 0);
        // playback of zero words: go idle, then a tick does nothing
        start_cmd(MODE_ARB, 4'd2, 12'd0, 8'd0);
        send_item(REQ_TICK, junk_item());
        // short triangle, aborted by stop
        start_cmd(MODE_TRI, 4'd3, 12'd1, 8'd1);
        tick_run(2, 0);
        start_cmd(MODE_STOP, 4'd0, 12'd0, 8'd0);
        send_item(REQ_TICK, junk_item());
    endtask

    // Mostly well-formed jobs with random content, plus aborts and noise. The whole
    // store is loaded by now, so any playback length reads written entries only.
    task automatic random_traffic(input int n);
        int         target;
        int         pick;
        int         sel;
        logic [11:0] pace;
        logic [7:0]  len;
        target = items_sent + n;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                start_cmd(MODE_FIXED, 4'($urandom_range(15)), 12'($urandom_range(4095)),
                          8'($urandom_range(255)));
            else if (pick < 15)
                start_cmd($urandom_range(1) ? MODE_REF_ON : MODE_REF_OFF,
                          4'($urandom_range(15)), 12'($urandom_range(4095)),
                          8'($urandom_range(255)));
            else if (pick < 20)
            begin
                // abort whatever runs: stop, an unused mode, or empty playback
                sel = $urandom_range(3);
                case (sel)
                    0: start_cmd(MODE_STOP, 4'($urandom_range(15)),
                                 12'($urandom_range(4095)), 8'($urandom_range(255)));
                    1: start_cmd(MODE_RSVD6, 4'($urandom_range(15)),
                                 12'($urandom_range(4095)), 8'($urandom_range(255)));
                    2: start_cmd(MODE_RSVD7, 4'($urandom_range(15)),
                                 12'($urandom_range(4095)), 8'($urandom_range(255)));
                    default: start_cmd(MODE_ARB, 4'($urandom_range(15)),
                                       12'($urandom_range(4095)), 8'd0);
                endcase
            end
            else if (pick < 45)
            begin
                // triangle: mostly a fast pace so several frames come out
                sel = $urandom_range(99);
                if (sel < 70)
                    pace = 12'($urandom_range(1, 4));
                else if (sel < 85)
                    pace = 12'd0;
                else
                    pace = 12'($urandom_range(4095));
                start_cmd(MODE_TRI, 4'($urandom_range(15)), pace, 8'($urandom_range(255)));
                tick_run($urandom_range(5, 60), 5);
            end
            else if (pick < 80)
            begin
                // playback: mostly short loops, sometimes long ones
                if ($urandom_range(9) == 0)
                    len = 8'($urandom_range(1, 255));
                else
                    len = 8'($urandom_range(1, 8));
                start_cmd(MODE_ARB, 4'($urandom_range(15)), 12'($urandom_range(4095)), len);
                tick_run($urandom_range(4, 40), 10);
            end
            else if (pick < 90)
            begin
                for (int i = 0; i < $urandom_range(1, 4); i++)
                    load_word(8'($urandom_range(255)), 24'($urandom_range(24'hFFFFFF)));
            end
            else
                send_item(2'($urandom_range(3)), junk_item());
        end
    endtask

    initial
    begin
        // Hold reset from time zero, then release it once
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: light sender gaps, heavy receiver stalls
        directed_items();
        for (int i = 0; i < 256; i++)
            load_word(8'(i), 24'($urandom_range(24'hFFFFFF)));
        random_traffic(100);

        // Phase 2: heavy sender gaps, light receiver stalls
        src_idle_pct  <= 62;
        sink_idle_pct <= 15;
        random_traffic(100);
        // endless triangle at the default pace, then the slowest pace: first frame only
        start_cmd(MODE_TRI, 4'd15, 12'd0, 8'd0);
        tick_run(3, 0);
        start_cmd(MODE_TRI, 4'd0, 12'hFFF, 8'hFF);
        tick_run(3, 0);
        start_cmd(MODE_STOP, 4'd15, 12'hFFF, 8'hFF);

        // Phase 3: no idling at all
        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
        random_traffic(100);
        // fast ramp at pace 1, stopped part way, then ticks that land on an idle block
        start_cmd(MODE_TRI, 4'd6, 12'd1, 8'd2);
        tick_run(12, 0);
        start_cmd(MODE_STOP, 4'd6, 12'd1, 8'd2);
        tick_run(2, 0);
        s_valid <= 1'b0;

        // Drain: wait until nothing is owed, then watch a little longer for strays
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (END_DRAIN) @(posedge clk);
        @(negedge clk);

        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dws_pkg.sv
rtl/core/dws_sdp_ram.sv
rtl/core/dac_waveform_sequencer_unit.sv
bench/dws_checker.sv
bench/tb_top.sv
